FILE: rtl/assert_macros.svh
// shared assertion macros for the sequencer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPFPS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SPFPS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/spfps_pkg.sv
`default_nettype none

package spfps_pkg;

  // page size and derived widths
  localparam int PAGE_BYTES = 64;
  localparam int PAGE_IDX_W = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int PAGE_CNT_W = $clog2(PAGE_BYTES + 1);

  // item opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_XFER   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_WEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_PP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_RDSR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILLER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_MASK  = 3'd4;

  // configuration reset values
  localparam logic [7:0] RST_CMD_WEN   = 8'h06;
  localparam logic [7:0] RST_CMD_PP    = 8'h02;
  localparam logic [7:0] RST_CMD_RDSR  = 8'h05;
  localparam logic [7:0] RST_FILLER    = 8'hFF;
  localparam logic [7:0] RST_BUSY_MASK = 8'h01;

  localparam int SECTOR_SHIFT = 12;
  localparam int ADDR_W = 24;

  // page buffer write request
  typedef struct packed {
    logic                  en;
    logic [PAGE_IDX_W-1:0] addr;
    logic [7:0]            data;
  } buf_wr_t;

endpackage

`default_nettype wire

FILE: rtl/spfps_page_buf.sv
`default_nettype none

module spfps_page_buf import spfps_pkg::*; (
  input  wire logic                  clk,
  input  wire buf_wr_t               wr,
  input  wire logic [PAGE_IDX_W-1:0] rd_addr,
  output logic      [7:0]            rd_data
);

  logic [7:0] mem [PAGE_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/spi_flash_page_program_sequencer.sv
// spi nor page program sequencer
// input channel (in_valid/in_ready): one item per transfer; opcode selects a
// page buffer load, a program start (sector and offset form the 24-bit
// address) or an exchange-done event carrying the byte just received
// output channel (out_valid/out_ready): one action per transfer telling the
// spi shifter whether to pulse chip select, the select level, and which byte
// to send; a final action with done_res reports the device no longer busy
// config channel (cfg_valid/cfg_ready): register index and 8-bit data, always
// ready; written by the user only while the block is idle (not enforced)
// an item's action is registered and appears in the cycle after its transfer
// throughput: one item per cycle; the output register is the only buffer, so
// the input takes a new item whenever that register is empty or being drained
// a receiver stall holds the action and backs pressure onto the input
// data bytes come from a 64-entry page buffer with a registered read port;
// the read address runs one step ahead of the data byte counter
// reset: idle phase, address and counters cleared, status zero, config
// registers to their defaults; page buffer contents are not cleared
`default_nettype none

module spi_flash_page_program_sequencer import spfps_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input items
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           opcode,
  input  wire logic [8:0]           sector,
  input  wire logic [11:0]          offset,
  input  wire logic [5:0]           load_index,
  input  wire logic [7:0]           load_byte,
  input  wire logic [7:0]           rx_byte,
  // result items
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      pulse_deselect,
  output logic                      select_level,
  output logic                      send,
  output logic [7:0]                tx_byte,
  output logic                      done_res,
  output logic [7:0]                last_status,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_AFTER_WEN,
    PH_ADDR,
    PH_DATA,
    PH_ENDWRITE,
    PH_RDSR,
    PH_DUMMY,
    PH_CHECK
  } phase_t;

  // config registers
  logic [7:0] cmd_write_enable;
  logic [7:0] cmd_page_program;
  logic [7:0] cmd_read_status;
  logic [7:0] filler_byte;
  logic [7:0] busy_mask;

  // sequence state
  phase_t                phase, phase_next;
  logic [ADDR_W-1:0]     target_address, target_address_next;
  logic [1:0]            address_bytes_left, address_bytes_left_next;
  logic [PAGE_CNT_W-1:0] data_bytes_left, data_bytes_left_next;
  logic [7:0]            status_seen, status_seen_next;

  // action produced by the current transfer
  logic       res_fire;
  logic       res_pulse;
  logic       res_level;
  logic       res_send;
  logic [7:0] res_tx;
  logic       res_done;

  logic                  in_fire;
  buf_wr_t               buf_wr;
  logic [PAGE_IDX_W-1:0] buf_rd_addr;
  logic [PAGE_CNT_W-1:0] buf_rd_pos;
  logic [7:0]            buf_rd_data;

  // input moves whenever the output register is free this cycle
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // prefetch the buffer byte the next data step will send
  assign buf_rd_pos  = PAGE_CNT_W'(PAGE_BYTES) - data_bytes_left_next;
  assign buf_rd_addr = buf_rd_pos[PAGE_IDX_W-1:0];

  spfps_page_buf u_page_buf (
    .clk     (clk),
    .wr      (buf_wr),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd_data)
  );

  always_comb begin
    phase_next              = phase;
    target_address_next     = target_address;
    address_bytes_left_next = address_bytes_left;
    data_bytes_left_next    = data_bytes_left;
    status_seen_next        = status_seen;
    res_fire                = 1'b0;
    res_pulse               = 1'b0;
    res_level               = 1'b0;
    res_send                = 1'b1;
    res_tx                  = 8'h00;
    res_done                = 1'b0;
    buf_wr.en               = 1'b0;
    buf_wr.addr             = PAGE_IDX_W'(load_index);
    buf_wr.data             = load_byte;

    if (in_fire) begin
      case (opcode)
        OP_LOAD: begin
          // loads only while idle and inside the page
          if (phase == PH_IDLE && 32'(load_index) < 32'(PAGE_BYTES)) begin
            buf_wr.en = 1'b1;
          end
        end
        OP_START: begin
          if (phase == PH_IDLE) begin
            target_address_next = ({15'd0, sector} << SECTOR_SHIFT)
                                  + {12'd0, offset};
            address_bytes_left_next = 2'd3;
            data_bytes_left_next    = PAGE_CNT_W'(PAGE_BYTES);
            phase_next              = PH_AFTER_WEN;
            res_fire                = 1'b1;
            res_tx                  = cmd_write_enable;
          end
        end
        OP_XFER: begin
          unique case (phase)
            PH_IDLE: begin
              // exchange done while idle is dropped
            end
            PH_AFTER_WEN: begin
              phase_next = PH_ADDR;
              res_fire   = 1'b1;
              res_pulse  = 1'b1;
              res_tx     = cmd_page_program;
            end
            PH_ADDR: begin
              // address goes out msb first
              case (address_bytes_left)
                2'd3:    res_tx = target_address[23:16];
                2'd2:    res_tx = target_address[15:8];
                default: res_tx = target_address[7:0];
              endcase
              if (address_bytes_left != 2'd0) begin
                address_bytes_left_next = address_bytes_left - 2'd1;
              end
              if (address_bytes_left_next == 2'd0) begin
                phase_next = PH_DATA;
              end
              res_fire = 1'b1;
            end
            PH_DATA: begin
              res_tx = buf_rd_data;
              if (data_bytes_left != '0) begin
                data_bytes_left_next = data_bytes_left - PAGE_CNT_W'(1);
              end
              if (data_bytes_left_next == '0) begin
                phase_next = PH_ENDWRITE;
              end
              res_fire = 1'b1;
            end
            PH_ENDWRITE: begin
              // deselect to start the internal program, clock a filler byte
              phase_next = PH_RDSR;
              res_fire   = 1'b1;
              res_pulse  = 1'b1;
              res_level  = 1'b1;
              res_tx     = filler_byte;
            end
            PH_RDSR: begin
              phase_next = PH_DUMMY;
              res_fire   = 1'b1;
              res_tx     = cmd_read_status;
            end
            PH_DUMMY: begin
              phase_next = PH_CHECK;
              res_fire   = 1'b1;
              res_tx     = filler_byte;
            end
            PH_CHECK: begin
              status_seen_next = rx_byte;
              res_fire         = 1'b1;
              res_pulse        = 1'b1;
              if ((rx_byte & busy_mask) != 8'h00) begin
                // still busy, poll again
                phase_next = PH_DUMMY;
                res_tx     = cmd_read_status;
              end else begin
                phase_next = PH_IDLE;
                res_level  = 1'b1;
                res_send   = 1'b0;
                res_done   = 1'b1;
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
        default: begin
          // unused opcode, no action
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      target_address     <= '0;
      address_bytes_left <= '0;
      data_bytes_left    <= '0;
      status_seen        <= '0;
      out_valid          <= 1'b0;
      cmd_write_enable   <= RST_CMD_WEN;
      cmd_page_program   <= RST_CMD_PP;
      cmd_read_status    <= RST_CMD_RDSR;
      filler_byte        <= RST_FILLER;
      busy_mask          <= RST_BUSY_MASK;
    end else begin
      phase              <= phase_next;
      target_address     <= target_address_next;
      address_bytes_left <= address_bytes_left_next;
      data_bytes_left    <= data_bytes_left_next;
      status_seen        <= status_seen_next;
      if (res_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CMD_WEN:   cmd_write_enable <= cfg_data;
          CFG_CMD_PP:    cmd_page_program <= cfg_data;
          CFG_CMD_RDSR:  cmd_read_status  <= cfg_data;
          CFG_FILLER:    filler_byte      <= cfg_data;
          CFG_BUSY_MASK: busy_mask        <= cfg_data;
          default: begin
            // writes past the register list are dropped
          end
        endcase
      end
    end
  end

  // result payload, loaded only when a new action is produced
  always_ff @(posedge clk) begin
    if (res_fire) begin
      pulse_deselect <= res_pulse;
      select_level   <= res_level;
      send           <= res_send;
      tx_byte        <= res_tx;
      done_res       <= res_done;
      last_status    <= status_seen_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spfps_checker.sv
`default_nettype none

`include "assert_macros.svh"

module spfps_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       pulse_deselect,
  input wire logic       select_level,
  input wire logic       send,
  input wire logic [7:0] tx_byte,
  input wire logic       done_res
);

  // a stalled action stays put
  `SPFPS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(tx_byte) && $stable(send) && $stable(done_res), "stalled action changed")

  // the done report carries no exchange and leaves the device deselected
  `SPFPS_ASSERT_IMP(a_done_shape, clk, rst, out_valid && done_res, !send && pulse_deselect && select_level && tx_byte == 8'h00, "malformed done report")

  // every action is either an exchange or the done report
  `SPFPS_ASSERT_IMP(a_send_or_done, clk, rst, out_valid, send != done_res, "action neither send nor done")

  // an empty output register never blocks the input
  `SPFPS_ASSERT_IMP(a_ready_when_empty, clk, rst, !out_valid, in_ready, "input blocked with empty output")

endmodule

bind spi_flash_page_program_sequencer spfps_checker u_spfps_checker (.*);

`default_nettype wire
